### rtl/core/scmd_pkg.sv
// Shared widths, codes, reset values and handshake structs for the slave clock block.
package scmd_pkg;

    // Field and state widths.
    localparam int MODE_W     = 2;
    localparam int FIELD_W    = 16;
    localparam int OP_W       = 6;
    localparam int STEP_W     = 8;
    localparam int PERIOD_W   = 20;
    localparam int ELAPSED_W  = 21;
    localparam int CFG_DATA_W = 8;

    // Divider operand widths: a 17-bit dividend covers master_step + 1.
    localparam int DVD_W = FIELD_W + 1;
    localparam int DVS_W = STEP_W;

    // Default for the largest multiply or divide factor.
    localparam int MAX_FACTOR_DEF = 16;

    // Reset values of the registers and state.
    localparam logic signed [OP_W-1:0] OPERATION_RST = 6'sd1;
    localparam logic [STEP_W-1:0]      WRAP_LEN_RST  = 8'd16;
    localparam logic [PERIOD_W-1:0]    PERIOD_RST    = PERIOD_W'(60000 / 90);
    localparam logic [ELAPSED_W-1:0]   ELAPSED_MAX   = {ELAPSED_W{1'b1}};

    // Item modes.
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SYNC  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_OPERATION = 1'b0;
    localparam logic CFG_WRAP_LEN  = 1'b1;

    // Request into the shared divider.
    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    // Response from the shared divider.
    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
        logic [DVS_W-1:0] remainder;
    } div_rsp_t;

endpackage

### rtl/core/scmd_div.sv
// Restoring divider, one quotient bit per cycle, shared by all divide and modulo steps.
module scmd_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  scmd_pkg::div_req_t req,
    output scmd_pkg::div_rsp_t rsp
);

    localparam int CNT_W = $clog2(scmd_pkg::DVD_W + 1);

    logic                        busy_reg;
    logic                        done_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [scmd_pkg::DVD_W-1:0]  dvd_reg;
    logic [scmd_pkg::DVS_W-1:0]  dvs_reg;
    logic [scmd_pkg::DVS_W-1:0]  rem_reg;
    logic [scmd_pkg::DVS_W:0]    shifted;
    logic                        fits;
    logic [scmd_pkg::DVS_W-1:0]  rem_next;

    // Trial subtraction of the divisor from the shifted partial remainder.
    always_comb
    begin
        shifted  = {rem_reg, dvd_reg[scmd_pkg::DVD_W-1]};
        fits     = shifted >= {1'b0, dvs_reg};
        rem_next = fits ? scmd_pkg::DVS_W'(shifted - {1'b0, dvs_reg})
                        : shifted[scmd_pkg::DVS_W-1:0];
    end

    // Control: busy while bits remain, done pulses for one cycle at the end.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(scmd_pkg::DVD_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath: the dividend shifts out at the top and the quotient shifts in below.
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[scmd_pkg::DVD_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = dvd_reg;
    assign rsp.remainder = rem_reg;

endmodule

### rtl/core/slave_clock_multiplier_divider.sv
// Slave clock locked to a master period: control FSM, clock state and output register.
// Path of an accepted item: clears and the unused mode go from S_EXEC to S_EMIT, ticks
// and zero-period syncs pass S_CHECK on the way, syncs that use the divider wait in S_DIV,
// and a step wrap passes S_CHECK and S_DIV; the divider loads its operands, then the bits.
// A new item is taken only in S_IDLE, and it may enter while the last beat waits.
// Reset: period 666 ms, elapsed and step cleared, operation 1, step wrap 16.
module slave_clock_multiplier_divider
#(
    parameter int MAX_FACTOR = scmd_pkg::MAX_FACTOR_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [scmd_pkg::MODE_W-1:0]       mode,
    input  logic [scmd_pkg::FIELD_W-1:0]      master_period_ms,
    input  logic [scmd_pkg::FIELD_W-1:0]      master_step,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [scmd_pkg::PERIOD_W-1:0]     pulse_period_ms,
    output logic [scmd_pkg::STEP_W-1:0]       step_index,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_index,
    input  logic [scmd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int MAG_W = $clog2(MAX_FACTOR + 1);
    localparam int CMP_W = ((MAG_W > scmd_pkg::STEP_W) ? MAG_W : scmd_pkg::STEP_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_CHECK,
        S_DIV,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        K_ALIGN,
        K_PERIOD,
        K_STEP
    } div_kind_t;

    state_t                                state_reg;
    div_kind_t                             kind_reg;
    logic signed [scmd_pkg::OP_W-1:0]      operation_reg;
    logic [scmd_pkg::STEP_W-1:0]           wrap_len_reg;
    logic [scmd_pkg::PERIOD_W-1:0]         period_reg;
    logic [scmd_pkg::ELAPSED_W-1:0]        elapsed_reg;
    logic [scmd_pkg::STEP_W-1:0]           step_reg;
    logic [scmd_pkg::MODE_W-1:0]           mode_reg;
    logic [scmd_pkg::FIELD_W-1:0]          mst_reg;
    logic [scmd_pkg::FIELD_W-1:0]          mcnt_reg;
    logic [scmd_pkg::PERIOD_W-1:0]         pulse_reg;
    logic                                  out_valid_reg;
    logic [scmd_pkg::PERIOD_W-1:0]         out_pulse_reg;
    logic [scmd_pkg::STEP_W-1:0]           out_step_reg;
    logic                                  start_reg;
    logic [scmd_pkg::DVD_W-1:0]            dividend_reg;
    logic [scmd_pkg::DVS_W-1:0]            divisor_reg;

    logic                                  op_neg;
    logic [scmd_pkg::OP_W:0]               op_abs;
    logic [MAG_W-1:0]                      mag;
    logic                                  free_run;
    logic [scmd_pkg::FIELD_W+MAG_W-1:0]    product;
    scmd_pkg::div_req_t                    div_req;
    scmd_pkg::div_rsp_t                    div_rsp;

    // Effective factor: zero counts as one, magnitude saturates at MAX_FACTOR.
    always_comb
    begin
        op_neg = operation_reg[scmd_pkg::OP_W-1];
        op_abs = op_neg ? (scmd_pkg::OP_W+1)'(-{operation_reg[scmd_pkg::OP_W-1], operation_reg})
                        : {1'b0, operation_reg};
        if (op_abs == '0)
        begin
            mag = MAG_W'(1);
        end
        else if (op_abs > (scmd_pkg::OP_W+1)'(MAX_FACTOR))
        begin
            mag = MAG_W'(MAX_FACTOR);
        end
        else
        begin
            mag = MAG_W'(op_abs);
        end
        // Multiply mode keeps pulsing on its own while the step index is below the effective factor minus one.
        free_run = !op_neg && ((CMP_W'(step_reg) + CMP_W'(1)) < CMP_W'(mag));
        product  = (scmd_pkg::FIELD_W+MAG_W)'(mst_reg) * (scmd_pkg::FIELD_W+MAG_W)'(mag);
    end

    // Configuration writes.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            operation_reg <= scmd_pkg::OPERATION_RST;
            wrap_len_reg  <= scmd_pkg::WRAP_LEN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                scmd_pkg::CFG_OPERATION: operation_reg <= $signed(cfg_data[scmd_pkg::OP_W-1:0]);
                scmd_pkg::CFG_WRAP_LEN:  wrap_len_reg  <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // Shared divider.
    assign div_req.start    = start_reg;
    assign div_req.dividend = dividend_reg;
    assign div_req.divisor  = divisor_reg;

    scmd_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Control FSM with the clock state and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= K_ALIGN;
            period_reg    <= scmd_pkg::PERIOD_RST;
            elapsed_reg   <= '0;
            step_reg      <= '0;
            mode_reg      <= '0;
            mst_reg       <= '0;
            mcnt_reg      <= '0;
            pulse_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_pulse_reg <= '0;
            out_step_reg  <= '0;
            start_reg     <= 1'b0;
            dividend_reg  <= '0;
            divisor_reg   <= '0;
        end
        else
        begin
            start_reg <= 1'b0;

            // The waiting beat leaves when the far side takes it; in S_EMIT the
            // load of the next beat decides the valid flag instead.
            if (out_valid_reg && out_ready && (state_reg != S_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        mode_reg  <= mode;
                        mst_reg   <= master_period_ms;
                        mcnt_reg  <= master_step;
                        pulse_reg <= '0;
                        state_reg <= S_EXEC;
                    end
                end

                S_EXEC:
                begin
                    unique case (mode_reg)
                        scmd_pkg::MODE_TICK:
                        begin
                            if (elapsed_reg != scmd_pkg::ELAPSED_MAX)
                            begin
                                elapsed_reg <= elapsed_reg + 1'b1;
                            end
                            state_reg <= S_CHECK;
                        end
                        scmd_pkg::MODE_SYNC:
                        begin
                            if (mst_reg == '0)
                            begin
                                state_reg <= S_CHECK;
                            end
                            else if (op_neg)
                            begin
                                // Divide: longer period, pulse only on aligned master steps.
                                period_reg   <= scmd_pkg::PERIOD_W'(product);
                                dividend_reg <= scmd_pkg::DVD_W'(mcnt_reg) + 1'b1;
                                divisor_reg  <= scmd_pkg::DVS_W'(mag);
                                kind_reg     <= K_ALIGN;
                                start_reg    <= 1'b1;
                                state_reg    <= S_DIV;
                            end
                            else
                            begin
                                // Multiply: shorter period, pulse on every such sync.
                                dividend_reg <= scmd_pkg::DVD_W'(mst_reg);
                                divisor_reg  <= scmd_pkg::DVS_W'(mag);
                                kind_reg     <= K_PERIOD;
                                start_reg    <= 1'b1;
                                state_reg    <= S_DIV;
                            end
                        end
                        scmd_pkg::MODE_CLEAR:
                        begin
                            elapsed_reg <= '0;
                            step_reg    <= '0;
                            state_reg   <= S_EMIT;
                        end
                        default:
                        begin
                            state_reg <= S_EMIT;
                        end
                    endcase
                end

                S_CHECK:
                begin
                    if (free_run && (elapsed_reg > scmd_pkg::ELAPSED_W'(period_reg)))
                    begin
                        elapsed_reg <= '0;
                        pulse_reg   <= period_reg;
                        if (wrap_len_reg == '0)
                        begin
                            step_reg  <= step_reg + 1'b1;
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            dividend_reg <= scmd_pkg::DVD_W'(step_reg) + 1'b1;
                            divisor_reg  <= wrap_len_reg;
                            kind_reg     <= K_STEP;
                            start_reg    <= 1'b1;
                            state_reg    <= S_DIV;
                        end
                    end
                    else
                    begin
                        state_reg <= S_EMIT;
                    end
                end

                S_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        unique case (kind_reg)
                            K_ALIGN:
                            begin
                                if (div_rsp.remainder == '0)
                                begin
                                    elapsed_reg <= '0;
                                    pulse_reg   <= period_reg;
                                end
                            end
                            K_PERIOD:
                            begin
                                period_reg  <= scmd_pkg::PERIOD_W'(div_rsp.quotient);
                                pulse_reg   <= scmd_pkg::PERIOD_W'(div_rsp.quotient);
                                elapsed_reg <= '0;
                            end
                            K_STEP:
                            begin
                                step_reg <= scmd_pkg::STEP_W'(div_rsp.remainder);
                            end
                            default:
                            begin
                            end
                        endcase
                        state_reg <= S_EMIT;
                    end
                end

                S_EMIT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_pulse_reg <= pulse_reg;
                        out_step_reg  <= step_reg;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready        = (state_reg == S_IDLE);
    assign out_valid       = out_valid_reg;
    assign pulse_period_ms = out_pulse_reg;
    assign step_index      = out_step_reg;

endmodule

### rtl/core/scmd_check.sv
// Port-level checks for the slave clock block, bound to the top level.
module scmd_check
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [scmd_pkg::PERIOD_W-1:0] pulse_period_ms,
    input logic [scmd_pkg::STEP_W-1:0]   step_index
);

    // A stalled result beat holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pulse_period_ms) && $stable(step_index))
        else $error("Stalled result beat changed or dropped.");

    // An accepted item keeps the block busy before it can take another.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##1 !in_ready ##1 !in_ready)
        else $error("Block took a new item too soon after an accepted one.");

    // A fresh result only appears after the block has been working.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("Result beat appeared without a busy period.");

    // Returning to ready always leaves a result beat behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_ready) |-> out_valid)
        else $error("Block became ready without presenting a result beat.");

endmodule

bind slave_clock_multiplier_divider scmd_check u_scmd_check
(
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .pulse_period_ms (pulse_period_ms),
    .step_index      (step_index)
);

### bench/slave_clock_multiplier_divider_test.sv
// Self-checking testbench for the slave clock multiplier and divider.
`timescale 1ns / 100ps

module slave_clock_multiplier_divider_test;

    // Mode 3 carries no operation; the block must leave its state alone.
    localparam logic [scmd_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

    // One item towards the block and one result beat from it.
    typedef struct {
        logic [scmd_pkg::MODE_W-1:0]  mode;
        logic [scmd_pkg::FIELD_W-1:0] master_period;
        logic [scmd_pkg::FIELD_W-1:0] master_step;
    } sync_item_t;

    typedef struct {
        logic [scmd_pkg::PERIOD_W-1:0] pulse;
        logic [scmd_pkg::STEP_W-1:0]   step;
    } slave_beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic [scmd_pkg::MODE_W-1:0]     mode = '0;
    logic [scmd_pkg::FIELD_W-1:0]    master_period_ms = '0;
    logic [scmd_pkg::FIELD_W-1:0]    master_step = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [scmd_pkg::PERIOD_W-1:0]   pulse_period_ms;
    logic [scmd_pkg::STEP_W-1:0]     step_index;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic                            cfg_index = scmd_pkg::CFG_OPERATION;
    logic [scmd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Handshake flags seen at the last rising edge.
    logic in_taken = 1'b0;
    logic out_taken = 1'b0;
    logic cfg_taken = 1'b0;

    // Items waiting for the feeder, and the beats the slave clock should give.
    sync_item_t  pending_items[$];
    slave_beat_t expected_beats[$];

    // Own copy of the configuration and the slave clock state.
    logic signed [scmd_pkg::OP_W-1:0] factor_reg = scmd_pkg::OPERATION_RST;
    logic [scmd_pkg::STEP_W-1:0]      wrap_reg = scmd_pkg::WRAP_LEN_RST;
    logic [scmd_pkg::PERIOD_W-1:0]    slave_period = scmd_pkg::PERIOD_RST;
    logic [scmd_pkg::ELAPSED_W-1:0]   slave_elapsed = '0;
    logic [scmd_pkg::STEP_W-1:0]      slave_step = '0;

    int idle_max = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_left = 0;
    int items_queued = 0;
    int items_taken = 0;
    int beats_checked = 0;
    int pulses_seen = 0;
    int writes_done = 0;
    int settings_run = 0;
    int fail_count = 0;

    slave_clock_multiplier_divider u_dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .mode             (mode),
        .master_period_ms (master_period_ms),
        .master_step      (master_step),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .pulse_period_ms  (pulse_period_ms),
        .step_index       (step_index),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #5 clk = ~clk;

    // The operation register with zero read as one and the magnitude saturated.
    function automatic int clamped_factor();
        int f;
        f = int'(factor_reg);
        if (f == 0)
            f = 1;
        if (f > scmd_pkg::MAX_FACTOR_DEF)
            f = scmd_pkg::MAX_FACTOR_DEF;
        if (f < -scmd_pkg::MAX_FACTOR_DEF)
            f = -scmd_pkg::MAX_FACTOR_DEF;
        return f;
    endfunction

    // Multiply mode makes its own pulses until factor-1 steps are done.
    function automatic bit free_running(input int f);
        return f > 0 && int'(slave_step) < f - 1;
    endfunction

    // Pulse once the elapsed time has gone past the period, and move the step on.
    function automatic logic [scmd_pkg::PERIOD_W-1:0] pulse_if_due();
        if (slave_elapsed > scmd_pkg::ELAPSED_W'(slave_period))
        begin
            slave_elapsed = '0;
            if (wrap_reg == '0)
                slave_step = slave_step + 1'b1;
            else
                slave_step = scmd_pkg::STEP_W'((int'(slave_step) + 1) % int'(wrap_reg));
            return slave_period;
        end
        return '0;
    endfunction

    // Advance the slave clock by one item and return the beat it gives.
    function automatic slave_beat_t advance_slave(input sync_item_t it);
        int          f;
        int          divisor;
        slave_beat_t r;
        f = clamped_factor();
        r.pulse = '0;
        case (it.mode)
            scmd_pkg::MODE_TICK:
            begin
                if (slave_elapsed != scmd_pkg::ELAPSED_MAX)
                    slave_elapsed = slave_elapsed + 1'b1;
                if (free_running(f))
                    r.pulse = pulse_if_due();
            end
            scmd_pkg::MODE_SYNC:
            begin
                if (it.master_period != '0)
                begin
                    if (f < 0)
                    begin
                        divisor = -f;
                        slave_period =
                            scmd_pkg::PERIOD_W'(int'(it.master_period) * divisor);
                        if ((int'(it.master_step) + 1) % divisor == 0)
                        begin
                            slave_elapsed = '0;
                            r.pulse = slave_period;
                        end
                    end
                    else
                    begin
                        slave_period = scmd_pkg::PERIOD_W'(int'(it.master_period) / f);
                        slave_elapsed = '0;
                        r.pulse = slave_period;
                    end
                end
                else if (free_running(f))
                    r.pulse = pulse_if_due();
            end
            scmd_pkg::MODE_CLEAR:
            begin
                slave_elapsed = '0;
                slave_step = '0;
            end
            default:
            begin
            end
        endcase
        r.step = slave_step;
        return r;
    endfunction

    // Feeder: presents queued items, with a random gap between one item and the next.
    always @(negedge clk)
    begin : feeder
        sync_item_t next_item;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap = send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                next_item = pending_items.pop_front();
                mode <= next_item.mode;
                master_period_ms <= next_item.master_period;
                master_step <= next_item.master_step;
                in_valid <= 1'b1;
                send_gap = $urandom_range(0, idle_max);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random stalls between beats, and two long hold-offs that back
    // the block up into its input.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
            begin
                recv_gap = $urandom_range(0, idle_max);
                if (beats_checked == 600 || beats_checked == 1500)
                    hold_left = 200;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap = recv_gap - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Monitor: checks each result beat, predicts each accepted item and keeps
    // the register copy in step with the configuration writes.
    always @(posedge clk)
    begin : monitor
        slave_beat_t want;
        sync_item_t  got;
        if (rst_n)
        begin
            in_taken <= in_valid && in_ready;
            out_taken <= out_valid && out_ready;
            cfg_taken <= cfg_valid && cfg_ready;

            if (out_valid && out_ready)
            begin
                beats_checked++;
                if (pulse_period_ms != '0)
                    pulses_seen++;
                if (expected_beats.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: beat expected none, got pulse %0d step %0d",
                             $time, pulse_period_ms, step_index);
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (pulse_period_ms !== want.pulse)
                    begin
                        fail_count++;
                        $display("%0t: pulse_period_ms expected %0d, got %0d",
                                 $time, want.pulse, pulse_period_ms);
                    end
                    if (step_index !== want.step)
                    begin
                        fail_count++;
                        $display("%0t: step_index expected %0d, got %0d",
                                 $time, want.step, step_index);
                    end
                end
            end

            if (in_valid && in_ready)
            begin
                got.mode = mode;
                got.master_period = master_period_ms;
                got.master_step = master_step;
                expected_beats.push_back(advance_slave(got));
                items_taken++;
            end

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == scmd_pkg::CFG_OPERATION)
                    factor_reg = cfg_data[scmd_pkg::OP_W-1:0];
                else
                    wrap_reg = cfg_data;
            end
        end
    end

    task automatic queue_item(input logic [scmd_pkg::MODE_W-1:0] m, input int per,
                              input int stp);
        sync_item_t it;
        it.mode = m;
        it.master_period = scmd_pkg::FIELD_W'(per);
        it.master_step = scmd_pkg::FIELD_W'(stp);
        pending_items.push_back(it);
        items_queued++;
    endtask

    // A run of master syncs with a steady period and counting master steps,
    // with ticks in between, now and then a zero-period sync or a clear.
    task automatic queue_sequence();
        int base;
        int per;
        int k;
        int n;
        base = $urandom_range(0, 65535);
        per = $urandom_range(1, 48);
        n = $urandom_range(2, 8);
        for (k = 0; k < n; k++)
        begin
            queue_item(scmd_pkg::MODE_SYNC, per, base + k);
            repeat ($urandom_range(0, 40))
                queue_item(scmd_pkg::MODE_TICK, $urandom, $urandom);
            if ($urandom_range(0, 7) == 0)
                queue_item(scmd_pkg::MODE_SYNC, 0, $urandom);
        end
        if ($urandom_range(0, 5) == 0)
            queue_item(scmd_pkg::MODE_CLEAR, $urandom, $urandom);
    endtask

    // Returns once the feeder is empty and every expected beat has arrived.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_items.size() != 0 || in_valid || expected_beats.size() != 0);
    endtask

    task automatic write_reg(input logic idx, input logic [scmd_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
        writes_done++;
    endtask

    // New setting of both registers; the spare bits of the operation are random.
    task automatic apply_setting(input int factor, input int wrap);
        wait_idle();
        write_reg(scmd_pkg::CFG_OPERATION, {2'($urandom), scmd_pkg::OP_W'(factor)});
        write_reg(scmd_pkg::CFG_WRAP_LEN, scmd_pkg::CFG_DATA_W'(wrap));
        settings_run++;
    endtask

    // Time limit on the whole run.
    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        int factor_picks[12];
        int wrap_picks[12];
        int idle_picks[3];
        int phase;
        int target;

        factor_picks = '{-32, -17, -16, -5, -2, -1, 0, 1, 2, 3, 16, 31};
        wrap_picks = '{0, 1, 255, 3, 2, 16, 7, 0, 255, 5, 1, 4};
        idle_picks = '{10, 0, 4};

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: plain tick, empty sync, largest fields, spare mode, clear.
        queue_item(scmd_pkg::MODE_TICK, 0, 0);
        queue_item(scmd_pkg::MODE_SYNC, 0, 0);
        queue_item(scmd_pkg::MODE_SYNC, 65535, 65535);
        queue_item(MODE_SPARE, 65535, 65535);
        queue_item(scmd_pkg::MODE_CLEAR, 65535, 0);

        // Multiply by four with a short step wrap, then a period that rounds to zero.
        apply_setting(4, 3);
        queue_item(scmd_pkg::MODE_SYNC, 8, 0);
        repeat (8)
            queue_item(scmd_pkg::MODE_TICK, 0, 0);
        queue_item(scmd_pkg::MODE_SYNC, 3, 0);
        queue_item(scmd_pkg::MODE_CLEAR, 0, 65535);

        // Largest divide: aligned and unaligned master steps, and a sum past 16 bits.
        apply_setting(-16, 255);
        queue_item(scmd_pkg::MODE_SYNC, 65535, 65535);
        queue_item(scmd_pkg::MODE_SYNC, 1, 0);
        queue_item(scmd_pkg::MODE_SYNC, 0, 15);
        queue_item(scmd_pkg::MODE_TICK, 65535, 65535);

        // Zero operation behaves as one, with the step wrap at 256.
        apply_setting(0, 0);
        queue_item(scmd_pkg::MODE_SYNC, 100, 7);
        queue_item(scmd_pkg::MODE_TICK, 0, 0);
        queue_item(scmd_pkg::MODE_SYNC, 0, 0);

        // An operation beyond the largest factor saturates.
        apply_setting(31, 1);
        queue_item(scmd_pkg::MODE_SYNC, 40, 0);
        repeat (4)
            queue_item(scmd_pkg::MODE_TICK, 0, 0);

        // Random phases: mostly well-formed sync runs, the rest noise.
        for (phase = 0; phase < 12; phase++)
        begin
            apply_setting(factor_picks[phase], wrap_picks[phase]);
            idle_max = idle_picks[phase % 3];
            target = items_queued + 95;
            while (items_queued < target)
            begin
                if ($urandom_range(0, 4) == 0)
                    queue_item(scmd_pkg::MODE_W'($urandom), $urandom, $urandom);
                else
                    queue_sequence();
            end
        end

        wait_idle();
        repeat (30) @(posedge clk);
        if (expected_beats.size() != 0)
        begin
            fail_count++;
            $display("%0t: %0d expected beats never arrived", $time, expected_beats.size());
        end

        $display("Ran %0d items through %0d register settings (%0d writes).",
                 items_taken, settings_run, writes_done);
        $display("Checked %0d result beats, %0d of them pulses; %0d failures.",
                 beats_checked, pulses_seen, fail_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
rtl/core/scmd_pkg.sv
rtl/core/scmd_div.sv
rtl/core/slave_clock_multiplier_divider.sv
rtl/core/scmd_check.sv
bench/slave_clock_multiplier_divider_test.sv
